// ----- rtl/cbse_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package cbse_pkg;

	localparam int MAX_POINTS = 64;
	localparam int ADDR_BITS  = $clog2(MAX_POINTS);
	localparam int COORD_BITS = 32;
	localparam int FRAC_BITS  = 16;
	localparam int W_BITS     = FRAC_BITS + 1;
	localparam int LR_BITS    = FRAC_BITS + 2;
	localparam int PROD_BITS  = W_BITS + LR_BITS;
	localparam int S_BITS     = 24;
	localparam int CNT_BITS   = 7;
	localparam int KV_BITS    = 8;
	localparam int ACC_BITS   = COORD_BITS + W_BITS + 3;
	// floor(v/3) == (v * RECIP3) >> RECIP3_SH for v below 2^RECIP3_SH
	localparam int RECIP3_SH  = 21;
	localparam int RECIP3     = ((1 << RECIP3_SH) + 1) / 3;

	localparam logic       REQ_WRITE  = 1'b0;
	localparam logic       REQ_SAMPLE = 1'b1;
	localparam logic       CFG_CLOSED = 1'b0;
	localparam logic       CFG_COUNT  = 1'b1;

	typedef struct packed {
		logic                         req_type;
		logic [ADDR_BITS-1:0]         point_index;
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic [S_BITS-1:0]            param_u;
	} req_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] curve_x;
		logic signed [COORD_BITS-1:0] curve_y;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SET2,
		ST_SET3,
		ST_MUL,
		ST_DIV,
		ST_BLEND,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_DONE
	} st_t;

	typedef struct packed {
		logic wr;
		logic start;
		logic set2;
		logic set3;
		logic mul;
		logic div;
		logic blend;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic step_last;
		logic blend_last;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

// ----- rtl/cbse_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cbse_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/cbse_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cbse_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cbse_pkg::cmd_t      cmd,
	output cbse_pkg::stat_t          stat,
	input  wire cbse_pkg::req_t      req_data,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire logic [6:0]          cfg_data,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output cbse_pkg::rsp_t           rsp_data
);

	localparam int F  = cbse_pkg::FRAC_BITS;
	localparam int CB = cbse_pkg::COORD_BITS;
	localparam int AB = cbse_pkg::ADDR_BITS;
	localparam int NB = cbse_pkg::CNT_BITS;
	localparam int KB = cbse_pkg::KV_BITS;
	localparam int SB = cbse_pkg::S_BITS;
	localparam int WB = cbse_pkg::W_BITS;
	localparam int LB = cbse_pkg::LR_BITS;
	localparam int PB = cbse_pkg::PROD_BITS;
	localparam int ABITS = cbse_pkg::ACC_BITS;
	localparam int RECIP_VB = LB + 1;

	function automatic logic [KB-1:0] knot_val(input logic [KB-1:0] i, input logic closed,
			input logic [NB-1:0] spans);
		logic [KB-1:0] im3;
		im3 = i - KB'(3);
		if (closed) begin
			return i;
		end else if (i < KB'(3)) begin
			return '0;
		end else if (im3 > KB'(spans)) begin
			return KB'(spans);
		end else begin
			return im3;
		end
	endfunction

	// rounded weight*distance / (d * 2^F)
	function automatic logic [WB-1:0] quo(input logic [PB-1:0] p, input logic [1:0] d);
		logic [PB:0]                          t;
		logic [RECIP_VB-1:0]                  v;
		logic [RECIP_VB+cbse_pkg::RECIP3_SH-1:0] m;
		t = '0;
		v = '0;
		m = '0;
		unique case (d)
			2'd0: return '0;
			2'd1: begin
				t = {1'b0, p} + (PB+1)'(1 << (F-1));
				return WB'(t >> F);
			end
			2'd2: begin
				t = {1'b0, p} + (PB+1)'(1 << F);
				return WB'(t >> (F+1));
			end
			default: begin
				t = {1'b0, p} + (PB+1)'(3 << (F-1));
				v = RECIP_VB'(t >> F);
				m = (RECIP_VB+cbse_pkg::RECIP3_SH)'(v)
					* (RECIP_VB+cbse_pkg::RECIP3_SH)'(cbse_pkg::RECIP3);
				return WB'(m >> cbse_pkg::RECIP3_SH);
			end
		endcase
	endfunction

	logic            closed_q;
	logic [NB-1:0]   count_q;
	logic [NB-1:0]   n_pts;
	logic [NB-1:0]   spans;
	logic [WB-1:0]   uq;

	logic [SB-1:0]   s_q;
	logic [AB-1:0]   k_q;
	logic [SB-1:0]   x_q;
	logic [KB-1:0]   ks;
	logic [KB-1:0]   k_raw;
	logic [LB-1:0]   left_q  [3:1];
	logic [LB-1:0]   right_q [3:1];
	logic [WB-1:0]   w_q     [4];
	logic [WB-1:0]   saved_q;
	logic [1:0]      j_q;
	logic [1:0]      r_q;
	logic [PB-1:0]   prod_a_q;
	logic [PB-1:0]   prod_b_q;
	logic [1:0]      d_q;
	logic [KB-1:0]   d_full;
	logic [WB-1:0]   quo_a;
	logic [WB-1:0]   quo_b;

	logic [1:0]      bc_q;
	logic [NB-1:0]   kr;
	logic [NB-1:0]   kr_wrap;
	logic [2*CB-1:0] rdata;
	logic            rd_vld_s1;
	logic [WB-1:0]   w_s1;
	logic            prod_vld_s2;
	logic signed [CB+WB:0] prod_x_s2;
	logic signed [CB+WB:0] prod_y_s2;
	logic signed [ABITS-1:0] acc_x_q;
	logic signed [ABITS-1:0] acc_y_q;
	logic signed [CB-1:0] out_x;
	logic signed [CB-1:0] out_y;

	function automatic logic signed [CB-1:0] round_sat(input logic signed [ABITS-1:0] a);
		logic signed [ABITS-1:0] t;
		logic signed [ABITS-F-1:0] q;
		logic signed [ABITS-F-1:0] hi;
		logic signed [ABITS-F-1:0] lo;
		hi = (ABITS-F)'(2 ** (CB-1) - 1);
		lo = -hi - (ABITS-F)'(1);
		t = a + ABITS'(1 << (F-1));
		q = (ABITS-F)'(t >>> F);
		if (q > hi) begin
			return {1'b0, {(CB-1){1'b1}}};
		end else if (q < lo) begin
			return {1'b1, {(CB-1){1'b0}}};
		end else begin
			return CB'(q);
		end
	endfunction

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closed_q <= 1'b0;
			count_q  <= NB'(4);
		end else if (cfg_we) begin
			unique case (cfg_index)
				cbse_pkg::CFG_CLOSED: closed_q <= cfg_data[0];
				cbse_pkg::CFG_COUNT:  count_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (count_q < NB'(4)) begin
			n_pts = NB'(4);
		end else if (count_q > NB'(cbse_pkg::MAX_POINTS)) begin
			n_pts = NB'(cbse_pkg::MAX_POINTS);
		end else begin
			n_pts = count_q;
		end
		spans = closed_q ? n_pts : n_pts - NB'(3);
		if (req_data.param_u[F-1:0] == '0 && req_data.param_u[SB-1:F] != '0) begin
			uq = WB'(1 << F);
		end else begin
			uq = {1'b0, req_data.param_u[F-1:0]};
		end
		k_raw = KB'(s_q >> F);
		ks    = KB'(k_q) + KB'(3);
		d_full = knot_val(ks + KB'(r_q) + KB'(1), closed_q, spans)
			- knot_val(ks + KB'(1) - KB'(j_q) + KB'(r_q), closed_q, spans);
		quo_a = quo(prod_a_q, d_q);
		quo_b = quo(prod_b_q, d_q);
		kr      = NB'(k_q) + NB'(bc_q);
		kr_wrap = (closed_q && kr >= n_pts) ? kr - n_pts : kr;
		out_x   = round_sat(acc_x_q);
		out_y   = round_sat(acc_y_q);
	end

	cbse_ram #(
		.WIDTH (2*CB),
		.DEPTH (cbse_pkg::MAX_POINTS)
	) u_ram (
		.clk   (clk),
		.we    (cmd.wr),
		.waddr (req_data.point_index),
		.wdata ({req_data.point_x, req_data.point_y}),
		.raddr (AB'(kr_wrap)),
		.rdata (rdata)
	);

	// span setup and Cox-de Boor triangle
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			s_q <= SB'(uq) * SB'(spans);
		end
		if (cmd.set2) begin
			k_q <= (k_raw >= KB'(spans)) ? AB'(spans - NB'(1)) : AB'(k_raw);
			x_q <= s_q + (closed_q ? SB'(3 << F) : SB'(0));
		end
		if (cmd.set3) begin
			for (int i = 1; i <= 3; i++) begin
				left_q[i]  <= LB'(x_q - {knot_val(ks + KB'(1) - KB'(i), closed_q, spans),
					F'(0)});
				right_q[i] <= LB'({knot_val(ks + KB'(i), closed_q, spans), F'(0)} - x_q);
			end
			w_q[0]  <= WB'(1 << F);
			saved_q <= '0;
			j_q     <= 2'd1;
			r_q     <= 2'd0;
		end
		if (cmd.mul) begin
			prod_a_q <= PB'(w_q[r_q]) * PB'(right_q[r_q + 2'd1]);
			prod_b_q <= PB'(w_q[r_q]) * PB'(left_q[j_q - r_q]);
			d_q      <= d_full[1:0];
		end
		if (cmd.div) begin
			w_q[r_q] <= saved_q + quo_a;
			if (r_q == j_q - 2'd1) begin
				w_q[j_q] <= quo_b;
				saved_q  <= '0;
				j_q      <= j_q + 2'd1;
				r_q      <= 2'd0;
			end else begin
				saved_q <= quo_b;
				r_q     <= r_q + 2'd1;
			end
		end
	end

	assign stat.step_last  = (j_q == 2'd3) && (r_q == 2'd2);
	assign stat.blend_last = (bc_q == 2'd3);
	assign stat.out_free   = !rsp_valid || !rsp_stall;

	// blend: read, multiply, accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1   <= 1'b0;
			prod_vld_s2 <= 1'b0;
			bc_q        <= '0;
		end else begin
			rd_vld_s1   <= cmd.blend;
			prod_vld_s2 <= rd_vld_s1;
			if (cmd.set3) begin
				bc_q <= '0;
			end else if (cmd.blend) begin
				bc_q <= bc_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		w_s1      <= w_q[bc_q];
		prod_x_s2 <= $signed(rdata[2*CB-1:CB]) * $signed({1'b0, w_s1});
		prod_y_s2 <= $signed(rdata[CB-1:0]) * $signed({1'b0, w_s1});
		if (cmd.set3) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
		end else if (prod_vld_s2) begin
			acc_x_q <= acc_x_q + ABITS'(prod_x_s2);
			acc_y_q <= acc_y_q + ABITS'(prod_y_s2);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rsp_data.curve_x <= out_x;
			rsp_data.curve_y <= out_y;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/cbse_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cbse_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	input  wire logic            req_type,
	output logic                 req_stall,
	input  wire cbse_pkg::stat_t stat,
	output cbse_pkg::cmd_t       cmd
);

	cbse_pkg::st_t state_q;
	cbse_pkg::st_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbse_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = (state_q != cbse_pkg::ST_IDLE);
		unique case (state_q)
			cbse_pkg::ST_IDLE: begin
				if (req_valid) begin
					if (req_type == cbse_pkg::REQ_SAMPLE) begin
						cmd.start = 1'b1;
						state_d   = cbse_pkg::ST_SET2;
					end else begin
						cmd.wr = 1'b1;
					end
				end
			end
			cbse_pkg::ST_SET2: begin
				cmd.set2 = 1'b1;
				state_d  = cbse_pkg::ST_SET3;
			end
			cbse_pkg::ST_SET3: begin
				cmd.set3 = 1'b1;
				state_d  = cbse_pkg::ST_MUL;
			end
			cbse_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = cbse_pkg::ST_DIV;
			end
			cbse_pkg::ST_DIV: begin
				cmd.div = 1'b1;
				state_d = stat.step_last ? cbse_pkg::ST_BLEND : cbse_pkg::ST_MUL;
			end
			cbse_pkg::ST_BLEND: begin
				cmd.blend = 1'b1;
				if (stat.blend_last) begin
					state_d = cbse_pkg::ST_DRAIN1;
				end
			end
			cbse_pkg::ST_DRAIN1: state_d = cbse_pkg::ST_DRAIN2;
			cbse_pkg::ST_DRAIN2: state_d = cbse_pkg::ST_DONE;
			cbse_pkg::ST_DONE: begin
				// hold until the output register is free
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = cbse_pkg::ST_IDLE;
				end
			end
			default: state_d = cbse_pkg::ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/cubic_bspline_point_eval_unit.sv -----
// Write requests are taken while the unit is idle and give no response.
// A sample request keeps the unit busy until its response is loaded (later if the
// output register is still stalled); the next request can be taken in the cycle the response appears.
// The span setup, six weight steps of a multiply and a divide each, and a four-read blend come first.
// Reset clears control and configuration (open mode, four points); the point
// memory holds nothing until written.
`timescale 1ns / 1ps
`default_nettype none
module cubic_bspline_point_eval_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire cbse_pkg::req_t req_data,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output cbse_pkg::rsp_t      rsp_data,
	input  wire logic           cfg_we,
	input  wire logic           cfg_index,
	input  wire logic [6:0]     cfg_data
);

	cbse_pkg::cmd_t  cmd;
	cbse_pkg::stat_t stat;

	cbse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req_data.req_type),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	cbse_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req_data  (req_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

endmodule
`default_nettype wire

// ----- rtl/cbse_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cbse_chk (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_stall,
	input wire cbse_pkg::req_t req_data,
	input wire logic           rsp_valid,
	input wire logic           rsp_stall,
	input wire cbse_pkg::rsp_t rsp_data
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("response changed while stalled");

	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> !$rose(rsp_valid))
		else $error("response right after a request");

	a_busy_after_sample: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req_data.req_type == cbse_pkg::REQ_SAMPLE |=> req_stall)
		else $error("sample request did not make the unit busy");

	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response appeared while idle");

endmodule

bind cubic_bspline_point_eval_unit cbse_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req_data  (req_data),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_data  (rsp_data)
);
`default_nettype wire
